@@ hdl/rgb_color_shader_assert.svh @@
// ----------------------------------------------------------------------------
// rgb_color_shader assertion macros
// concurrent assertion helpers on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_SHADER_ASSERT_SVH
`define RGB_COLOR_SHADER_ASSERT_SVH

// same-cycle implication
`define RCS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rgb_color_shader: assertion failed");

// next-cycle implication
`define RCS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rgb_color_shader: assertion failed");

`endif

@@ hdl/rcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rcs_pkg
// types and constants shared by the colour shader pipeline
// ----------------------------------------------------------------------------
package rcs_pkg;

  typedef enum logic [1:0] {
    MODE_GRAY   = 2'd0,
    MODE_SEPIA  = 2'd1,
    MODE_INVERT = 2'd2,
    MODE_PASS   = 2'd3
  } shader_mode_e;

  localparam int unsigned ChW   = 8;
  localparam int unsigned CoefW = 12;
  localparam int unsigned ProdW = 20;  // 8 x 12 bit product, max 803250
  localparam int unsigned RowW  = 21;  // sum of three products
  localparam int unsigned SumW  = 10;  // r + g + b, max 765
  localparam int unsigned QShift = 12;

  // floor(x / 3) = (x * 683) >> 11 for x below 768
  localparam logic [SumW-1:0] GRAY_RECIP = 10'd683;
  localparam int unsigned GrayShift = 11;
  localparam int unsigned GrayProdW = 19;

  // sepia matrix in Q0.12, rows give R', G', B', columns weight R, G, B
  localparam logic [0:2][0:2][CoefW-1:0] SEPIA_Q12 = '{
    '{12'd1610, 12'd3150, 12'd774},
    '{12'd1430, 12'd2810, 12'd688},
    '{12'd1114, 12'd2187, 12'd537}
  };

  typedef struct packed {
    logic [23:0] pixel_in;
    logic        last_in;
  } pix_in_t;

  typedef struct packed {
    logic [23:0] pixel_out;
    logic        last_out;
  } pix_out_t;

  // after the multiplier stage
  typedef struct packed {
    logic [0:2][0:2][ProdW-1:0] prod;
    logic [SumW-1:0]            chan_sum;
    logic [23:0]                pixel;
    logic                       last;
    shader_mode_e               mode;
  } mul_stage_t;

  // after the adder stage
  typedef struct packed {
    logic [0:2][ChW-1:0] sepia;
    logic [ChW-1:0]      gray;
    logic [23:0]         pixel;
    logic                last;
    shader_mode_e        mode;
  } add_stage_t;

endpackage

@@ hdl/rcs_mul_stage.sv @@
// ----------------------------------------------------------------------------
// rcs_mul_stage
// first pipeline stage: sepia partial products and channel sum
// ----------------------------------------------------------------------------
module rcs_mul_stage import rcs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  pix_in_t      data_i,
  input  shader_mode_e mode_i,
  output logic         valid_o,
  input  logic         ready_i,
  output mul_stage_t   data_o
);

  logic       valid_q;
  mul_stage_t data_d, data_q;

  always_comb begin
    logic [ChW-1:0] ch;
    data_d = '0;
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        ch = data_i.pixel_in[23 - 8*col -: 8];
        data_d.prod[row][col] = ProdW'(SEPIA_Q12[row][col]) * ProdW'(ch);
      end
    end
    data_d.chan_sum = SumW'(data_i.pixel_in[23:16]) + SumW'(data_i.pixel_in[15:8])
                    + SumW'(data_i.pixel_in[7:0]);
    data_d.pixel = data_i.pixel_in;
    data_d.last  = data_i.last_in;
    data_d.mode  = mode_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/rcs_add_stage.sv @@
// ----------------------------------------------------------------------------
// rcs_add_stage
// second pipeline stage: sepia row sums and grayscale mean
// ----------------------------------------------------------------------------
module rcs_add_stage import rcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  mul_stage_t data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output add_stage_t data_o
);

  logic       valid_q;
  add_stage_t data_d, data_q;

  always_comb begin
    logic [RowW-1:0]      row_sum;
    logic [GrayProdW-1:0] gray_prod;
    data_d = '0;
    for (int row = 0; row < 3; row++) begin
      row_sum = RowW'(data_i.prod[row][0]) + RowW'(data_i.prod[row][1])
              + RowW'(data_i.prod[row][2]);
      // truncating shift, upper bits dropped so the channel wraps
      data_d.sepia[row] = row_sum[QShift +: ChW];
    end
    gray_prod   = GrayProdW'(data_i.chan_sum) * GrayProdW'(GRAY_RECIP);
    data_d.gray = gray_prod[GrayShift +: ChW];
    data_d.pixel = data_i.pixel;
    data_d.last  = data_i.last;
    data_d.mode  = data_i.mode;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/rcs_out_stage.sv @@
// ----------------------------------------------------------------------------
// rcs_out_stage
// last pipeline stage: mode select into the output register
// ----------------------------------------------------------------------------
module rcs_out_stage import rcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  add_stage_t data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output pix_out_t   data_o
);

  logic     valid_q;
  pix_out_t data_d, data_q;

  always_comb begin
    data_d.last_out = data_i.last;
    case (data_i.mode)
      MODE_GRAY:   data_d.pixel_out = {data_i.gray, data_i.gray, data_i.gray};
      MODE_SEPIA:  data_d.pixel_out = {data_i.sepia[0], data_i.sepia[1], data_i.sepia[2]};
      MODE_INVERT: data_d.pixel_out = ~data_i.pixel;
      default:     data_d.pixel_out = data_i.pixel;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/rgb_color_shader.sv @@
// ----------------------------------------------------------------------------
// rgb_color_shader
// per-pixel grayscale, sepia, invert or passthrough on a 24-bit rgb stream
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i    | sink
//  out     | out_valid_o, out_ready_i, out_data_o | source
//  cfg     | cfg_we_i, cfg_data_i                 | write only
//
//  one pixel per cycle while the output is not stalled, through three register
//  stages (multiplier stage, adder stage, select stage); an accepted input
//  goes through the multiplier and adder registers into the output register
//  reset clears the stage valid bits and sets the mode to passthrough
//  a stall on the output fills the stages one by one; the input is held off
//  only once all three stages hold a transaction
// ----------------------------------------------------------------------------
module rgb_color_shader import rcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pix_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pix_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i
);

  shader_mode_e mode_q;
  logic         mul_valid, mul_ready;
  logic         add_valid, add_ready;
  mul_stage_t   mul_data;
  add_stage_t   add_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else if (cfg_we_i) begin
      mode_q <= shader_mode_e'(cfg_data_i);
    end
  end

  rcs_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .mode_i  (mode_q),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  rcs_add_stage u_add (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (add_valid),
    .ready_i (add_ready),
    .data_o  (add_data)
  );

  rcs_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (add_valid),
    .ready_o (add_ready),
    .data_i  (add_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

`include "rgb_color_shader_assert.svh"

  // input backpressure only when every stage is occupied
  `RCS_ASSERT_IMPL(a_no_bubble_stall, !in_ready_o, mul_valid && add_valid && out_valid_o)

  // grayscale reciprocal gives the exact floor of the mean
  `RCS_ASSERT_NEXT(a_gray_floor, mul_valid && mul_ready,
    (10'(add_data.gray) * 10'd3 <= $past(mul_data.chan_sum)) &&
    ($past(mul_data.chan_sum) - 10'(add_data.gray) * 10'd3 < 10'd3))

  // the adder stage never drops a held transaction while stalled
  `RCS_ASSERT_NEXT(a_add_hold, add_valid && !add_ready, add_valid && $stable(add_data))

endmodule
